// ===== src/nbpa_pkg.sv =====
`timescale 1ns / 1ps
package nbpa_pkg;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] m;
    } t_particle;

    localparam int DSQ_W = 50;
    localparam int ACC_W = 58;
    localparam int TERM_W = 54;
    localparam logic [DSQ_W-1:0] NEAR_LIMIT = 50'd65536;

endpackage

// ===== src/nbpa_mem.sv =====
`timescale 1ns / 1ps
module nbpa_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_wr_addr,
    input  nbpa_pkg::t_particle   i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output nbpa_pkg::t_particle   o_rd_data
);

    nbpa_pkg::t_particle r_mem [DEPTH];
    nbpa_pkg::t_particle r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/nbpa_div.sv =====
`timescale 1ns / 1ps
module nbpa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [49:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [49:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [49:0] r_dvs, n_dvs;
    logic [50:0] rem_sh;
    logic        fits;

    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        fits   = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd63;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? 50'(rem_sh - {1'b0, r_dvs}) : rem_sh[49:0];
            n_quo = {r_quo[62:0], fits};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/nbpa_sqrt.sv =====
`timescale 1ns / 1ps
module nbpa_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [63:0] r_v, n_v;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    always_comb begin
        trial  = r_res + r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_v    = i_value;
            n_res  = '0;
            n_bit  = 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v   = r_v - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == 64'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ===== src/nbody_pairwise_acceleration.sv =====
`timescale 1ns / 1ps
// Loads one particle per request (start high while busy low) into an on-chip store; a request
// with load_last high also starts the direct-sum pass (not when the configured count is zero),
// during which busy stays high. Results come out one per particle in index order, each on
// the result ports for exactly one cycle with o_strobe high; the receiver cannot stall them.
// The pass walks the pairs one at a time through a single store read port; a pair closer
// than 1.0 is summed directly, while a farther pair waits on the bit-serial square root and
// the shared bit-serial divider (two quotients per axis).
module nbody_pairwise_acceleration #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  i_particle_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_mass,
    input  logic        i_load_last,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [5:0]  o_result_index,
    output logic [31:0] o_acc_x,
    output logic [31:0] o_acc_y,
    output logic [31:0] o_acc_z,
    output logic        o_saturated,
    output logic        o_result_last
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int ACC_W = nbpa_pkg::ACC_W;
    localparam int TERM_W = nbpa_pkg::TERM_W;
    localparam int DSQ_W = nbpa_pkg::DSQ_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RDI   = 5'd1;
    localparam logic [4:0] S_LDI   = 5'd2;
    localparam logic [4:0] S_RDJ   = 5'd3;
    localparam logic [4:0] S_LDJ   = 5'd4;
    localparam logic [4:0] S_SQ    = 5'd5;
    localparam logic [4:0] S_CMP   = 5'd6;
    localparam logic [4:0] S_NMUL  = 5'd7;
    localparam logic [4:0] S_NACC  = 5'd8;
    localparam logic [4:0] S_SQRT  = 5'd9;
    localparam logic [4:0] S_SQRTW = 5'd10;
    localparam logic [4:0] S_D1    = 5'd11;
    localparam logic [4:0] S_D1W   = 5'd12;
    localparam logic [4:0] S_MUL2  = 5'd13;
    localparam logic [4:0] S_D2    = 5'd14;
    localparam logic [4:0] S_D2W   = 5'd15;
    localparam logic [4:0] S_NEXTJ = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    localparam logic signed [ACC_W-1:0] ACC_HI = 58'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_LO = -58'sd2147483648;

    logic [4:0]          r_state, n_state;
    logic [6:0]          r_count;
    logic [6:0]          r_n, n_n;
    logic [AW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_j, n_j;
    logic [1:0]          r_k, n_k;
    nbpa_pkg::t_particle r_pi, n_pi;
    logic [30:0]         r_m, n_m;
    logic [31:0]         r_mag [3];
    logic [31:0]         n_mag [3];
    logic [2:0]          r_neg, n_neg;
    logic [DSQ_W-1:0]    r_dsq, n_dsq;
    logic [63:0]         r_prod, n_prod;
    logic [31:0]         r_root, n_root;
    logic [32:0]         r_u, n_u;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [ACC_W-1:0] n_acc [3];

    logic                r_strobe;
    logic [5:0]          r_res_index;
    logic [31:0]         r_out [3];
    logic                r_sat;
    logic                r_last;

    logic                load_req;
    logic                mem_we;
    nbpa_pkg::t_particle wr_data;
    nbpa_pkg::t_particle rd_data;
    logic [AW-1:0]       rd_addr;
    logic [6:0]          n_eff;
    logic                last_i;
    logic                last_j;

    logic                div_start, div_done;
    logic [63:0]         div_dividend, div_quotient;
    logic [49:0]         div_divisor;
    logic                sqrt_start, sqrt_done;
    logic [31:0]         sqrt_root;

    logic signed [32:0]  diff [3];
    logic [31:0]         pj_c [3];
    logic [31:0]         pi_c [3];
    logic [31:0]         mag_k;
    logic                neg_k;
    logic [TERM_W-1:0]   term;
    logic signed [ACC_W-1:0] term_s;
    logic signed [ACC_W-1:0] acc_k;

    logic                sat_c [3];
    logic [31:0]         clip_c [3];

    assign load_req = start && !busy;
    assign mem_we   = load_req && (7'(i_particle_index) < 7'(MAX_PARTICLES));
    assign wr_data  = '{x: i_pos_x, y: i_pos_y, z: i_pos_z, m: i_mass};
    assign rd_addr  = (r_state == S_RDI) ? r_i : r_j;
    assign n_eff    = (r_count > 7'(MAX_PARTICLES)) ? 7'(MAX_PARTICLES) : r_count;
    assign last_i   = 7'(r_i) == r_n - 7'd1;
    assign last_j   = 7'(r_j) == r_n - 7'd1;

    nbpa_mem #(
        .DEPTH(MAX_PARTICLES),
        .AW(AW)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(mem_we),
        .i_wr_addr(i_particle_index[AW-1:0]),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign div_start    = (r_state == S_D1) || (r_state == S_D2);
    assign div_dividend = (r_state == S_D1) ? {3'b0, mag_k, 29'b0}
                                            : 64'(54'(r_prod[63:14]) * 54'd10);
    assign div_divisor  = (r_state == S_D1) ? 50'(r_root) : r_dsq;

    nbpa_div u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_dividend(div_dividend),
        .i_divisor(div_divisor),
        .o_done(div_done),
        .o_quotient(div_quotient)
    );

    assign sqrt_start = r_state == S_SQRT;

    nbpa_sqrt u_sqrt (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sqrt_start),
        .i_value({r_dsq, 14'b0}),
        .o_done(sqrt_done),
        .o_root(sqrt_root)
    );

    always_comb begin
        pj_c[0] = rd_data.x;
        pj_c[1] = rd_data.y;
        pj_c[2] = rd_data.z;
        pi_c[0] = r_pi.x;
        pi_c[1] = r_pi.y;
        pi_c[2] = r_pi.z;
        for (int a = 0; a < 3; a++) begin
            diff[a] = $signed({pj_c[a][31], pj_c[a]}) - $signed({pi_c[a][31], pi_c[a]});
            sat_c[a] = (r_acc[a] > ACC_HI) || (r_acc[a] < ACC_LO);
            if (r_acc[a] > ACC_HI) begin
                clip_c[a] = 32'h7FFF_FFFF;
            end else if (r_acc[a] < ACC_LO) begin
                clip_c[a] = 32'h8000_0000;
            end else begin
                clip_c[a] = r_acc[a][31:0];
            end
        end
        mag_k  = r_mag[r_k];
        neg_k  = r_neg[r_k];
        acc_k  = r_acc[r_k];
        term   = (r_state == S_NACC) ? TERM_W'(52'(r_prod[63:16]) * 52'd10)
                                     : div_quotient[TERM_W-1:0];
        term_s = $signed(ACC_W'(term));
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_pi    = r_pi;
        n_m     = r_m;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_dsq   = r_dsq;
        n_prod  = r_prod;
        n_root  = r_root;
        n_u     = r_u;
        n_acc   = r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (load_req && i_load_last && (n_eff != 7'd0)) begin
                    n_n     = n_eff;
                    n_i     = '0;
                    n_state = S_RDI;
                end
            end
            S_RDI: n_state = S_LDI;
            S_LDI: begin
                n_pi    = rd_data;
                n_j     = '0;
                for (int a = 0; a < 3; a++) begin
                    n_acc[a] = '0;
                end
                n_state = S_RDJ;
            end
            S_RDJ: n_state = S_LDJ;
            S_LDJ: begin
                n_m = rd_data.m;
                for (int a = 0; a < 3; a++) begin
                    n_neg[a] = diff[a][32];
                    n_mag[a] = diff[a][32] ? 32'(-diff[a]) : diff[a][31:0];
                end
                n_k     = 2'd0;
                n_dsq   = '0;
                n_state = (r_j == r_i) ? S_NEXTJ : S_SQ;
            end
            S_SQ: begin
                n_prod = 64'(mag_k) * 64'(mag_k);
                n_dsq  = r_dsq + DSQ_W'(n_prod[63:16]);
                n_k    = r_k + 2'd1;
                if (r_k == 2'd2) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_k     = 2'd0;
                n_state = (r_dsq < nbpa_pkg::NEAR_LIMIT) ? S_NMUL : S_SQRT;
            end
            S_NMUL: begin
                n_prod  = 64'(mag_k) * 64'(r_m);
                n_state = S_NACC;
            end
            S_NACC: begin
                n_acc[r_k] = neg_k ? acc_k - term_s : acc_k + term_s;
                n_k        = r_k + 2'd1;
                n_state    = (r_k == 2'd2) ? S_NEXTJ : S_NMUL;
            end
            S_SQRT: n_state = S_SQRTW;
            S_SQRTW: begin
                if (sqrt_done) begin
                    n_root  = sqrt_root;
                    n_state = S_D1;
                end
            end
            S_D1: n_state = S_D1W;
            S_D1W: begin
                if (div_done) begin
                    n_u     = div_quotient[32:0];
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                n_prod  = 64'(r_m) * 64'(r_u);
                n_state = S_D2;
            end
            S_D2: n_state = S_D2W;
            S_D2W: begin
                if (div_done) begin
                    n_acc[r_k] = neg_k ? acc_k - term_s : acc_k + term_s;
                    n_k        = r_k + 2'd1;
                    n_state    = (r_k == 2'd2) ? S_NEXTJ : S_D1;
                end
            end
            S_NEXTJ: begin
                if (last_j) begin
                    n_state = S_OUT;
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = S_RDJ;
                end
            end
            S_OUT: begin
                if (last_i) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_RDI;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 7'd64;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= r_state == S_OUT;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
        r_n    <= n_n;
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_pi   <= n_pi;
        r_m    <= n_m;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_dsq  <= n_dsq;
        r_prod <= n_prod;
        r_root <= n_root;
        r_u    <= n_u;
        r_acc  <= n_acc;
        if (r_state == S_OUT) begin
            r_res_index <= 6'(r_i);
            r_out       <= clip_c;
            r_sat       <= sat_c[0] || sat_c[1] || sat_c[2];
            r_last      <= last_i;
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_result_index = r_res_index;
    assign o_acc_x        = r_out[0];
    assign o_acc_y        = r_out[1];
    assign o_acc_z        = r_out[2];
    assign o_saturated    = r_sat;
    assign o_result_last  = r_last;

endmodule

// ===== bench/nbpa_checker.sv =====
`timescale 1ns / 1ps
module nbpa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [5:0]  i_particle_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_mass,
    input  logic        i_load_last,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_strobe,
    input  logic [5:0]  i_result_index,
    input  logic [31:0] i_acc_x,
    input  logic [31:0] i_acc_y,
    input  logic [31:0] i_acc_z,
    input  logic        i_saturated,
    input  logic        i_result_last,
    output int          o_errors,
    output int          o_pending
);

    localparam int SLOTS = 64;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        sat;
        logic        last;
    } t_accel;

    nbpa_pkg::t_particle bodies [SLOTS];
    logic [6:0] body_count;
    t_accel     accel_q [$];

    assign o_pending = accel_q.size();

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clip_acc(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic predict_accels();
        int n;
        longint acc [3];
        longint d [3];
        longint unsigned mag [3];
        longint unsigned dsq, m, r, u, t;
        t_accel a;
        logic sat;
        n = (body_count > SLOTS) ? SLOTS : body_count;
        for (int i = 0; i < n; i++) begin
            acc = '{0, 0, 0};
            for (int j = 0; j < n; j++) begin
                if (j == i) continue;
                m = bodies[j].m;
                d[0] = longint'($signed(bodies[j].x)) - longint'($signed(bodies[i].x));
                d[1] = longint'($signed(bodies[j].y)) - longint'($signed(bodies[i].y));
                d[2] = longint'($signed(bodies[j].z)) - longint'($signed(bodies[i].z));
                dsq = 0;
                for (int k = 0; k < 3; k++) begin
                    mag[k] = (d[k] < 0) ? longint'(-d[k]) : d[k];
                    dsq += (mag[k] * mag[k]) >> 16;
                end
                if (dsq < 65536) begin
                    for (int k = 0; k < 3; k++) begin
                        t = ((mag[k] * m) >> 16) * 10;
                        acc[k] += (d[k] < 0) ? -longint'(t) : longint'(t);
                    end
                end else begin
                    r = floor_sqrt(dsq << 14);
                    for (int k = 0; k < 3; k++) begin
                        u = (mag[k] << 29) / r;
                        t = (((m * u) >> 14) * 10) / dsq;
                        acc[k] += (d[k] < 0) ? -longint'(t) : longint'(t);
                    end
                end
            end
            sat = 1'b0;
            a.index = i[5:0];
            a.ax = clip_acc(acc[0], sat);
            a.ay = clip_acc(acc[1], sat);
            a.az = clip_acc(acc[2], sat);
            a.sat = sat;
            a.last = (i + 1 == n);
            accel_q.push_back(a);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_accel w;
        if (!i_rst_n) begin
            body_count = 7'd64;
            accel_q.delete();
        end else begin
            if (i_strobe) begin
                if (accel_q.size() == 0) begin
                    report("unexpected result index", i_result_index, 0);
                end else begin
                    w = accel_q.pop_front();
                    if (i_result_index !== w.index) report("result_index", i_result_index, w.index);
                    if (i_acc_x !== w.ax) report("acc_x", i_acc_x, w.ax);
                    if (i_acc_y !== w.ay) report("acc_y", i_acc_y, w.ay);
                    if (i_acc_z !== w.az) report("acc_z", i_acc_z, w.az);
                    if (i_saturated !== w.sat) report("saturated", i_saturated, w.sat);
                    if (i_result_last !== w.last) report("result_last", i_result_last, w.last);
                end
            end
            if (i_cfg_we) body_count = i_cfg_wdata;
            if (i_start && !i_busy) begin
                bodies[i_particle_index] = '{i_pos_x, i_pos_y, i_pos_z, i_mass};
                if (i_load_last) predict_accels();
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 600;
    localparam int ITEM_TARGET = 370;

    typedef enum int {SPREAD_FAR, SPREAD_NEAR, SPREAD_MIXED} t_spread;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [5:0]  particle_index = '0;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [30:0] mass = '0;
    logic        load_last = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        strobe, saturated, result_last;
    logic [5:0]  result_index;
    logic [31:0] acc_x, acc_y, acc_z;
    int          errors, pending;
    int          sent = 0;
    int          idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    nbody_pairwise_acceleration u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_particle_index(particle_index), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_pos_z(pos_z), .i_mass(mass), .i_load_last(load_last),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_strobe(strobe), .o_result_index(result_index), .o_acc_x(acc_x),
        .o_acc_y(acc_y), .o_acc_z(acc_z), .o_saturated(saturated),
        .o_result_last(result_last)
    );

    nbpa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_particle_index(particle_index), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_pos_z(pos_z), .i_mass(mass), .i_load_last(load_last),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_strobe(strobe), .i_result_index(result_index), .i_acc_x(acc_x),
        .i_acc_y(acc_y), .i_acc_z(acc_z), .i_saturated(saturated),
        .i_result_last(result_last), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [30:0] m, logic last);
        int gap;
        logic ready;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        particle_index <= idx;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        mass <= m;
        load_last <= last;
        forever begin
            @(negedge i_clk);
            ready = !busy;
            @(posedge i_clk);
            if (ready) break;
        end
        sent++;
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [6:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord(t_spread spread, logic [31:0] base);
        if (spread == SPREAD_FAR || (spread == SPREAD_MIXED && $urandom_range(0, 1)))
            return $urandom;
        return base + $urandom_range(0, 32'h6000) - 32'h3000;
    endfunction

    function automatic logic [30:0] pick_mass();
        logic [30:0] m;
        m = 31'($urandom);
        return m >> $urandom_range(0, 30);
    endfunction

    task automatic load_set(int n, t_spread spread);
        int order [$];
        logic [31:0] bx, by, bz;
        int k;
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        for (int i = 0; i < $urandom_range(0, 2); i++)
            send_request(6'($urandom_range(0, 63)), $urandom, $urandom, $urandom, pick_mass(),
                         1'b0);
        for (int i = 0; i < n; i++) begin
            k = order[i];
            send_request(k[5:0], pick_coord(spread, bx), pick_coord(spread, by),
                         pick_coord(spread, bz), pick_mass(), i == n - 1);
        end
        release_start();
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_count(7'd2);
        send_request(6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_request(6'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1'b1);
        release_start();
        send_request(6'd0, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 1'b0);
        send_request(6'd1, 32'hFFFF, 32'h0, 32'hFFFF_0001, 31'h7FFF_FFFF, 1'b1);
        release_start();
        send_request(6'd0, 32'h1234_0000, 32'h0, 32'h0, 31'h10000, 1'b0);
        send_request(6'd1, 32'h1234_0000, 32'h0, 32'h0, 31'h10000, 1'b1);
        release_start();
        write_count(7'd3);
        send_request(6'd2, 32'h0001_0000, 32'h0, 32'h0, 31'h10000, 1'b0);
        send_request(6'd0, 32'h0, 32'h0001_0000, 32'h0, 31'h20000, 1'b0);
        send_request(6'd1, 32'h0, 32'h0, 32'h0000_8000, 31'h30000, 1'b1);
        release_start();
        write_count(7'd1);
        send_request(6'd0, $urandom, $urandom, $urandom, 31'h7FFF_FFFF, 1'b1);
        release_start();
        write_count(7'd0);
        send_request(6'd5, $urandom, $urandom, $urandom, pick_mass(), 1'b1);
        release_start();
        write_count(7'd64);
        load_set(64, SPREAD_NEAR);
        write_count(7'd127);
        load_set(64, SPREAD_NEAR);

        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) != 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(2, 5);
                write_count(n[6:0]);
            end else begin
                drain();
                n = ($urandom_range(0, 1) != 0) ? 2 : 3;
                write_count(n[6:0]);
            end
            load_set(n, t_spread'($urandom_range(0, 2)));
            if ($urandom_range(0, 3) == 0) load_set(n, t_spread'($urandom_range(0, 2)));
        end

        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
